// ----- hdl/osc_pkg.sv -----
`default_nettype none

package osc_pkg;

  // Field widths
  localparam int OP_W   = 2;
  localparam int KIND_W = 2;
  localparam int ID_W   = 64;
  localparam int VER_W  = 16;
  localparam int LAT_W  = 31;
  localparam int LON_W  = 32;
  localparam int SLOT_W = 4;
  localparam int CNT_W  = 32;
  localparam int DV_W   = 5;

  // Opcodes
  localparam logic [OP_W-1:0] OP_RECORD = 2'd0;
  localparam logic [OP_W-1:0] OP_READ   = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

  // Object kinds
  localparam logic [KIND_W-1:0] KIND_NODE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_WAY  = 2'd1;

  // Initial extremes
  localparam logic signed [ID_W-1:0]  ID_INIT_LOW    = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [ID_W-1:0]  ID_INIT_HIGH   = 64'sh8000_0000_0000_0000;
  localparam logic signed [LAT_W-1:0] LAT_INIT_NORTH = -31'sd900000000;
  localparam logic signed [LAT_W-1:0] LAT_INIT_SOUTH = 31'sd900000000;
  localparam logic signed [LON_W-1:0] LON_INIT_WEST  = 32'sd1800000000;
  localparam logic signed [LON_W-1:0] LON_INIT_EAST  = -32'sd1800000000;

  // Running statistics
  typedef struct packed {
    logic [CNT_W-1:0]        node_total;
    logic [CNT_W-1:0]        way_total;
    logic signed [ID_W-1:0]  node_id_low;
    logic signed [ID_W-1:0]  node_id_high;
    logic signed [ID_W-1:0]  way_id_low;
    logic signed [ID_W-1:0]  way_id_high;
    logic signed [LAT_W-1:0] lat_north;
    logic signed [LON_W-1:0] lon_west;
    logic signed [LAT_W-1:0] lat_south;
    logic signed [LON_W-1:0] lon_east;
  } stats_t;

  // Token that walks the version cell chain
  typedef struct packed {
    logic              vld;
    logic [OP_W-1:0]   op;
    logic [VER_W-1:0]  ver;
    logic [SLOT_W-1:0] slot;
    logic              found;
    logic              inserted;
    logic [VER_W-1:0]  entry;
  } tok_t;

endpackage

`default_nettype wire

// ----- hdl/object_stats_collector.sv -----
// Each item walks the full chain of version cells, one cell per cycle; a new
// item is taken only once the last result has moved to the output register.
// A finished result waits in the output register while the next item runs.
// Reset (rst, synchronous) restores all counts and extremes and empties
// the version set; slot contents stay undefined until written.
`default_nettype none

module object_stats_collector import osc_pkg::*; #(
  parameter int VERSION_SLOTS = 16
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic [OP_W-1:0]         opcode,
  input  wire logic [KIND_W-1:0]       obj_kind,
  input  wire logic signed [ID_W-1:0]  obj_id,
  input  wire logic [VER_W-1:0]        obj_version,
  input  wire logic signed [LAT_W-1:0] lat_e7,
  input  wire logic signed [LON_W-1:0] lon_e7,
  input  wire logic [SLOT_W-1:0]       slot_index,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic [CNT_W-1:0]             node_count,
  output logic [CNT_W-1:0]             way_count,
  output logic signed [ID_W-1:0]       min_node_id,
  output logic signed [ID_W-1:0]       max_node_id,
  output logic signed [ID_W-1:0]       min_way_id,
  output logic signed [ID_W-1:0]       max_way_id,
  output logic signed [LAT_W-1:0]      north_lat,
  output logic signed [LON_W-1:0]      west_lon,
  output logic signed [LAT_W-1:0]      south_lat,
  output logic signed [LON_W-1:0]      east_lon,
  output logic [DV_W-1:0]              distinct_versions,
  output logic [VER_W-1:0]             version_entry
);

  localparam int FILL_W = $clog2(VERSION_SLOTS + 1);
  localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(VERSION_SLOTS);
  localparam logic [DV_W-1:0]   DV_MAX   = '1;

  logic              accept;
  logic              busy;
  logic              load;
  logic              pend_valid;
  logic [VER_W-1:0]  pend_entry;
  logic [FILL_W-1:0] fill;
  logic [DV_W-1:0]   fill_sat;
  stats_t            st;
  tok_t              chain [VERSION_SLOTS+1];
  tok_t              tok_exit;
  logic [VERSION_SLOTS-1:0] cell_vld;

  assign accept   = in_valid && in_ready;
  assign in_ready = !busy;
  assign load     = pend_valid && (!out_valid || out_ready);
  assign tok_exit = chain[VERSION_SLOTS];

  // Statistics registers, updated as the item is taken
  osc_stats u_stats (
    .clk      (clk),
    .rst      (rst),
    .upd      (accept),
    .opcode   (opcode),
    .obj_kind (obj_kind),
    .obj_id   (obj_id),
    .lat_e7   (lat_e7),
    .lon_e7   (lon_e7),
    .st       (st)
  );

  // Token launched into the first cell
  always_comb begin
    chain[0].vld      = accept;
    chain[0].op       = opcode;
    chain[0].ver      = obj_version;
    chain[0].slot     = slot_index;
    chain[0].found    = 1'b0;
    chain[0].inserted = 1'b0;
    chain[0].entry    = '0;
  end

  // Row of version cells
  for (genvar k = 0; k < VERSION_SLOTS; k++) begin : g_cell
    osc_cell #(
      .IDX    (k),
      .FILL_W (FILL_W)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .fill    (fill),
      .tok_in  (chain[k]),
      .tok_out (chain[k+1])
    );
    assign cell_vld[k] = chain[k+1].vld;
  end

  // Version set fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (accept && (opcode == OP_CLEAR)) begin
      fill <= '0;
    end else if (tok_exit.vld && tok_exit.inserted) begin
      fill <= fill + 1'b1;
    end
  end

  assign fill_sat = (32'(fill) > 32'(DV_MAX)) ? DV_MAX : DV_W'(fill);

  // Item tracking and held chain result
  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      if (accept) begin
        busy <= 1'b1;
      end else if (load) begin
        busy <= 1'b0;
      end
      if (tok_exit.vld) begin
        pend_valid <= 1'b1;
      end else if (load) begin
        pend_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tok_exit.vld) begin
      pend_entry <= tok_exit.entry;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      node_count        <= st.node_total;
      way_count         <= st.way_total;
      min_node_id       <= st.node_id_low;
      max_node_id       <= st.node_id_high;
      min_way_id        <= st.way_id_low;
      max_way_id        <= st.way_id_high;
      north_lat         <= st.lat_north;
      west_lon          <= st.lon_west;
      south_lat         <= st.lat_south;
      east_lon          <= st.lon_east;
      distinct_versions <= fill_sat;
      version_entry     <= pend_entry;
    end
  end

  // At most one token in the chain at a time
  a_one_token: assert property (@(posedge clk) disable iff (rst)
    $onehot0(cell_vld))
    else $error("more than one token in version chain");

  // A token never leaves the chain while a result is still held
  a_exit_free: assert property (@(posedge clk) disable iff (rst)
    tok_exit.vld |-> !pend_valid)
    else $error("chain result overwrote held result");

  // Fill level stays within the slot count
  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_MAX)
    else $error("version fill beyond slot count");

  // Results are only loaded for an item in flight
  a_load_busy: assert property (@(posedge clk) disable iff (rst)
    load |-> busy)
    else $error("result loaded with no item in flight");

  // A chain token exists only while an item is in flight
  a_token_busy: assert property (@(posedge clk) disable iff (rst)
    (|cell_vld) |-> busy)
    else $error("token in chain with no item in flight");

endmodule

`default_nettype wire

// ----- hdl/osc_cell.sv -----
`default_nettype none

module osc_cell import osc_pkg::*; #(
  parameter int IDX    = 0,
  parameter int FILL_W = 5
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [FILL_W-1:0] fill,
  input  wire tok_t              tok_in,
  output tok_t                   tok_out
);

  localparam logic [FILL_W-1:0] POS     = FILL_W'(IDX);
  localparam bit                SLOT_OK = (IDX < (1 << SLOT_W));
  localparam logic [SLOT_W-1:0] SLOT_ID = SLOT_W'(IDX);

  logic [VER_W-1:0] value;
  logic             live;
  logic             hit;
  logic             put;
  tok_t             tok_next;

  // Local compare against the stored version
  assign live = POS < fill;
  assign hit  = tok_in.vld && (tok_in.op == OP_RECORD) && live && (value == tok_in.ver);
  assign put  = tok_in.vld && (tok_in.op == OP_RECORD) && !tok_in.found && (POS == fill);

  always_comb begin
    tok_next = tok_in;
    if (hit) begin
      tok_next.found = 1'b1;
    end
    if (put) begin
      tok_next.inserted = 1'b1;
    end
    if (tok_in.vld && (tok_in.op == OP_READ) && live && SLOT_OK && (tok_in.slot == SLOT_ID)) begin
      tok_next.entry = value;
    end
  end

  // Slot storage, written when a new version lands here; a clear frees it again
  always_ff @(posedge clk) begin
    if (put) begin
      value <= tok_in.ver;
    end
  end

  // Hand the token to the next cell
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.vld <= 1'b0;
    end else begin
      tok_out <= tok_next;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/osc_stats.sv -----
`default_nettype none

module osc_stats import osc_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    upd,
  input  wire logic [OP_W-1:0]         opcode,
  input  wire logic [KIND_W-1:0]       obj_kind,
  input  wire logic signed [ID_W-1:0]  obj_id,
  input  wire logic signed [LAT_W-1:0] lat_e7,
  input  wire logic signed [LON_W-1:0] lon_e7,
  output stats_t                       st
);

  stats_t st_next;

  // Counts, id ranges and bounding box; a clear restores their initial values
  always_comb begin
    st_next = st;
    case (opcode)
      OP_RECORD: begin
        if (obj_kind == KIND_NODE) begin
          if (st.node_total != '1) begin
            st_next.node_total = st.node_total + 1'b1;
          end
          if (lat_e7 > st.lat_north) st_next.lat_north = lat_e7;
          if (lon_e7 < st.lon_west)  st_next.lon_west  = lon_e7;
          if (lat_e7 < st.lat_south) st_next.lat_south = lat_e7;
          if (lon_e7 > st.lon_east)  st_next.lon_east  = lon_e7;
          if (obj_id < st.node_id_low)  st_next.node_id_low  = obj_id;
          if (obj_id > st.node_id_high) st_next.node_id_high = obj_id;
        end else if (obj_kind == KIND_WAY) begin
          if (st.way_total != '1) begin
            st_next.way_total = st.way_total + 1'b1;
          end
          if (obj_id < st.way_id_low)  st_next.way_id_low  = obj_id;
          if (obj_id > st.way_id_high) st_next.way_id_high = obj_id;
        end
      end
      OP_CLEAR: begin
        st_next.node_total   = '0;
        st_next.way_total    = '0;
        st_next.node_id_low  = ID_INIT_LOW;
        st_next.node_id_high = ID_INIT_HIGH;
        st_next.way_id_low   = ID_INIT_LOW;
        st_next.way_id_high  = ID_INIT_HIGH;
        st_next.lat_north    = LAT_INIT_NORTH;
        st_next.lon_west     = LON_INIT_WEST;
        st_next.lat_south    = LAT_INIT_SOUTH;
        st_next.lon_east     = LON_INIT_EAST;
      end
      default: begin
        st_next = st;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st.node_total   <= '0;
      st.way_total    <= '0;
      st.node_id_low  <= ID_INIT_LOW;
      st.node_id_high <= ID_INIT_HIGH;
      st.way_id_low   <= ID_INIT_LOW;
      st.way_id_high  <= ID_INIT_HIGH;
      st.lat_north    <= LAT_INIT_NORTH;
      st.lon_west     <= LON_INIT_WEST;
      st.lat_south    <= LAT_INIT_SOUTH;
      st.lon_east     <= LON_INIT_EAST;
    end else if (upd) begin
      st <= st_next;
    end
  end

endmodule

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
`default_nettype none

module tb_top;
  import osc_pkg::*;

  localparam int VER_SLOTS   = 16;
  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_WAIT  = VER_SLOTS + 24;
  localparam int PHASE_ITEMS = 367;

  // Codes the package leaves unnamed
  localparam logic [OP_W-1:0]   OP_UNUSED  = 2'd3;
  localparam logic [KIND_W-1:0] KIND_OTHER = 2'd2;
  localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

  localparam logic signed [ID_W-1:0] ID_MIN = 64'sh8000_0000_0000_0000;
  localparam logic signed [ID_W-1:0] ID_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;

  // One map object as it enters the block
  typedef struct packed {
    logic [OP_W-1:0]         op;
    logic [KIND_W-1:0]       kind;
    logic signed [ID_W-1:0]  id;
    logic [VER_W-1:0]        ver;
    logic signed [LAT_W-1:0] lat;
    logic signed [LON_W-1:0] lon;
    logic [SLOT_W-1:0]       slot;
  } map_obj_t;

  // Statistics summary as the block reports it
  typedef struct packed {
    stats_t           st;
    logic [DV_W-1:0]  n_ver;
    logic [VER_W-1:0] entry;
  } summary_t;

  typedef struct {
    map_obj_t obj;
    bit       pinned;
    summary_t want;
  } dir_row_t;

  logic clk;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [OP_W-1:0] opcode = OP_RECORD;
  logic [KIND_W-1:0] obj_kind = KIND_NODE;
  logic signed [ID_W-1:0] obj_id = '0;
  logic [VER_W-1:0] obj_version = '0;
  logic signed [LAT_W-1:0] lat_e7 = '0;
  logic signed [LON_W-1:0] lon_e7 = '0;
  logic [SLOT_W-1:0] slot_index = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [CNT_W-1:0] node_count;
  logic [CNT_W-1:0] way_count;
  logic signed [ID_W-1:0] min_node_id;
  logic signed [ID_W-1:0] max_node_id;
  logic signed [ID_W-1:0] min_way_id;
  logic signed [ID_W-1:0] max_way_id;
  logic signed [LAT_W-1:0] north_lat;
  logic signed [LON_W-1:0] west_lon;
  logic signed [LAT_W-1:0] south_lat;
  logic signed [LON_W-1:0] east_lon;
  logic [DV_W-1:0] distinct_versions;
  logic [VER_W-1:0] version_entry;

  object_stats_collector #(.VERSION_SLOTS(VER_SLOTS)) DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .opcode(opcode), .obj_kind(obj_kind), .obj_id(obj_id), .obj_version(obj_version),
    .lat_e7(lat_e7), .lon_e7(lon_e7), .slot_index(slot_index),
    .out_valid(out_valid), .out_ready(out_ready),
    .node_count(node_count), .way_count(way_count),
    .min_node_id(min_node_id), .max_node_id(max_node_id),
    .min_way_id(min_way_id), .max_way_id(max_way_id),
    .north_lat(north_lat), .west_lon(west_lon),
    .south_lat(south_lat), .east_lon(east_lon),
    .distinct_versions(distinct_versions), .version_entry(version_entry)
  );

  // Mirror of the collector state
  stats_t acc;
  logic [VER_W-1:0] ver_set [VER_SLOTS];
  int unsigned ver_count;

  summary_t summary_q[$];
  dir_row_t dir_rows[$];

  int send_idle_pct;
  int recv_idle_pct;
  int mismatches;
  int results_seen;
  int n_records, n_reads, n_clears, n_unused, full_drops, fill_peaks;
  int unsigned cycle_cnt;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic stats_t fresh_stats();
    stats_t s;
    s.node_total   = '0;
    s.way_total    = '0;
    s.node_id_low  = ID_MAX;
    s.node_id_high = ID_MIN;
    s.way_id_low   = ID_MAX;
    s.way_id_high  = ID_MIN;
    s.lat_north    = LAT_INIT_NORTH;
    s.lon_west     = LON_INIT_WEST;
    s.lat_south    = LAT_INIT_SOUTH;
    s.lon_east     = LON_INIT_EAST;
    return s;
  endfunction

  function automatic map_obj_t mk_obj(logic [OP_W-1:0] op, logic [KIND_W-1:0] kind,
                                      logic signed [ID_W-1:0] id, logic [VER_W-1:0] ver,
                                      logic signed [LAT_W-1:0] lat,
                                      logic signed [LON_W-1:0] lon,
                                      logic [SLOT_W-1:0] slot);
    map_obj_t o;
    o.op = op; o.kind = kind; o.id = id; o.ver = ver;
    o.lat = lat; o.lon = lon; o.slot = slot;
    return o;
  endfunction

  // Advance the mirrored statistics by one item and report the summary after it
  task automatic apply_object(input map_obj_t o, output summary_t s);
    bit hit;
    hit = 1'b0;
    s.entry = '0;
    case (o.op)
      OP_RECORD: begin
        n_records++;
        if (o.kind == KIND_NODE) begin
          if (acc.node_total != '1) acc.node_total = acc.node_total + 1;
          if ($signed(o.lat) > $signed(acc.lat_north)) acc.lat_north = o.lat;
          if ($signed(o.lon) < $signed(acc.lon_west)) acc.lon_west = o.lon;
          if ($signed(o.lat) < $signed(acc.lat_south)) acc.lat_south = o.lat;
          if ($signed(o.lon) > $signed(acc.lon_east)) acc.lon_east = o.lon;
          if ($signed(o.id) < $signed(acc.node_id_low)) acc.node_id_low = o.id;
          if ($signed(o.id) > $signed(acc.node_id_high)) acc.node_id_high = o.id;
        end else if (o.kind == KIND_WAY) begin
          if (acc.way_total != '1) acc.way_total = acc.way_total + 1;
          if ($signed(o.id) < $signed(acc.way_id_low)) acc.way_id_low = o.id;
          if ($signed(o.id) > $signed(acc.way_id_high)) acc.way_id_high = o.id;
        end
        // every kind feeds the version set
        for (int i = 0; i < ver_count; i++)
          if (ver_set[i] == o.ver) hit = 1'b1;
        if (!hit) begin
          if (ver_count < VER_SLOTS) begin
            ver_set[ver_count] = o.ver;
            ver_count++;
            if (ver_count == VER_SLOTS) fill_peaks++;
          end else begin
            full_drops++;
          end
        end
      end
      OP_READ: begin
        n_reads++;
        if (o.slot < ver_count) s.entry = ver_set[o.slot];
      end
      OP_CLEAR: begin
        n_clears++;
        acc = fresh_stats();
        ver_count = 0;
      end
      default: n_unused++;
    endcase
    s.st = acc;
    s.n_ver = (ver_count > 31) ? DV_W'(31) : DV_W'(ver_count);
  endtask

  // Random item, weighted toward records of plausible map data
  function automatic map_obj_t rand_obj();
    map_obj_t o;
    int p;
    longint t;
    o.slot = SLOT_W'($urandom_range(0, 15));
    o.kind = KIND_NODE;
    p = $urandom_range(0, 99);
    if (p < 3) o.op = OP_CLEAR;
    else if (p < 15) o.op = OP_READ;
    else if (p < 18) o.op = OP_UNUSED;
    else o.op = OP_RECORD;

    p = $urandom_range(0, 99);
    if (p < 45) o.kind = KIND_NODE;
    else if (p < 80) o.kind = KIND_WAY;
    else if (p < 92) o.kind = KIND_OTHER;
    else o.kind = KIND_SPARE;

    p = $urandom_range(0, 99);
    if (p < 60) begin
      o.id = {$urandom, $urandom};
    end else if (p < 90) begin
      t = longint'($urandom_range(0, 2000)) - 1000;
      o.id = t;
    end else begin
      case ($urandom_range(0, 5))
        0: o.id = ID_MIN;
        1: o.id = ID_MIN + 1;
        2: o.id = ID_MAX;
        3: o.id = ID_MAX - 1;
        4: o.id = '0;
        default: o.id = '1;
      endcase
    end

    // small pool so the version set fills up and sees repeats
    p = $urandom_range(0, 99);
    if (p < 70) o.ver = VER_W'($urandom_range(0, 19));
    else if (p < 90) o.ver = VER_W'($urandom);
    else o.ver = $urandom_range(0, 1) ? '1 : '0;

    if ($urandom_range(0, 99) < 85) begin
      t = longint'($urandom_range(0, 1800000000)) - 900000000;
      o.lat = t[LAT_W-1:0];
    end else begin
      o.lat = LAT_W'($urandom);
    end
    if ($urandom_range(0, 99) < 85) begin
      t = longint'($urandom_range(0, 32'd3600000000)) - 1800000000;
      o.lon = t[LON_W-1:0];
    end else begin
      o.lon = LON_W'($urandom);
    end
    return o;
  endfunction

  // Present one item and hold it until the block takes it
  task automatic send_item(input map_obj_t o, input bit pinned, input summary_t want);
    summary_t s;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    opcode      <= o.op;
    obj_kind    <= o.kind;
    obj_id      <= o.id;
    obj_version <= o.ver;
    lat_e7      <= o.lat;
    lon_e7      <= o.lon;
    slot_index  <= o.slot;
    do @(posedge clk); while (!in_ready);
    apply_object(o, s);
    summary_q.push_back(pinned ? want : s);
  endtask

  // Hold off the sender until every summary has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (summary_q.size() != 0) @(posedge clk);
  endtask

  task automatic field_check(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch on result %0d, %s: expected %h, got %h",
                 results_seen, name, want, got);
    end
  endtask

  task automatic check_summary(input summary_t got);
    summary_t want;
    results_seen++;
    if (summary_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("result %0d arrived with nothing outstanding", results_seen);
    end else begin
      want = summary_q.pop_front();
      field_check("node_count",        want.st.node_total,   got.st.node_total);
      field_check("way_count",         want.st.way_total,    got.st.way_total);
      field_check("min_node_id",       want.st.node_id_low,  got.st.node_id_low);
      field_check("max_node_id",       want.st.node_id_high, got.st.node_id_high);
      field_check("min_way_id",        want.st.way_id_low,   got.st.way_id_low);
      field_check("max_way_id",        want.st.way_id_high,  got.st.way_id_high);
      field_check("north_lat",         want.st.lat_north,    got.st.lat_north);
      field_check("west_lon",          want.st.lon_west,     got.st.lon_west);
      field_check("south_lat",         want.st.lat_south,    got.st.lat_south);
      field_check("east_lon",          want.st.lon_east,     got.st.lon_east);
      field_check("distinct_versions", want.n_ver,           got.n_ver);
      field_check("version_entry",     want.entry,           got.entry);
    end
  endtask

  // Receiver: random back-pressure, compare on each accepted result
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready)
        check_summary({node_count, way_count, min_node_id, max_node_id,
                       min_way_id, max_way_id, north_lat, west_lon,
                       south_lat, east_lon, distinct_versions, version_entry});
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("run stopped by watchdog after %0d cycles", cycle_cnt);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Directed rows; the obvious ones carry their expected summary
  task automatic load_directed();
    summary_t rs, w;
    summary_t none;
    rs = '{fresh_stats(), '0, '0};
    none = '0;
    // untouched block, unused opcode and empty-set reads
    dir_rows.push_back('{mk_obj(OP_UNUSED, KIND_NODE, 64'sd5, 16'd1, 31'sd7, 32'sd7, 4'd3),
                         1'b1, rs});
    dir_rows.push_back('{mk_obj(OP_READ, KIND_NODE, '0, '0, '0, '0, 4'd0), 1'b1, rs});
    dir_rows.push_back('{mk_obj(OP_READ, KIND_WAY, '0, '0, '0, '0, 4'd15), 1'b1, rs});
    // first node at the south-east corner with the lowest id
    w = rs;
    w.st.node_total = 1;
    w.st.node_id_low = ID_MIN; w.st.node_id_high = ID_MIN;
    w.st.lat_north = -31'sd900000000; w.st.lat_south = -31'sd900000000;
    w.st.lon_west = 32'sd1800000000; w.st.lon_east = 32'sd1800000000;
    w.n_ver = 1;
    dir_rows.push_back('{mk_obj(OP_RECORD, KIND_NODE, ID_MIN, 16'h0000,
                                -31'sd900000000, 32'sd1800000000, 4'd0), 1'b1, w});
    // second node at the opposite corner opens the box to the full globe
    w.st.node_total = 2;
    w.st.node_id_high = ID_MAX;
    w.st.lat_north = 31'sd900000000;
    w.st.lon_west = -32'sd1800000000;
    w.n_ver = 2;
    dir_rows.push_back('{mk_obj(OP_RECORD, KIND_NODE, ID_MAX, 16'hFFFF,
                                31'sd900000000, -32'sd1800000000, 4'd15), 1'b1, w});
    // slot reads inside and beyond the stored set
    dir_rows.push_back('{mk_obj(OP_READ, KIND_NODE, '0, '0, '0, '0, 4'd0), 1'b0, none});
    dir_rows.push_back('{mk_obj(OP_READ, KIND_NODE, '0, '0, '0, '0, 4'd1), 1'b0, none});
    dir_rows.push_back('{mk_obj(OP_READ, KIND_NODE, '0, '0, '0, '0, 4'd2), 1'b0, none});
    // ways, a known version and the two non-counted kinds
    dir_rows.push_back('{mk_obj(OP_RECORD, KIND_WAY, -64'sd1, 16'h0000, '0, '0, 4'd0),
                         1'b0, none});
    dir_rows.push_back('{mk_obj(OP_RECORD, KIND_WAY, 64'sd0, 16'd5, '1, '1, 4'd0),
                         1'b0, none});
    dir_rows.push_back('{mk_obj(OP_RECORD, KIND_OTHER, 64'sd123, 16'd7, '0, '0, 4'd0),
                         1'b0, none});
    dir_rows.push_back('{mk_obj(OP_RECORD, KIND_SPARE, 64'sd9, 16'd9, '0, '0, 4'd0),
                         1'b0, none});
    dir_rows.push_back('{mk_obj(OP_UNUSED, KIND_WAY, '1, '1, '1, '1, '1), 1'b0, none});
    dir_rows.push_back('{mk_obj(OP_READ, KIND_NODE, '0, '0, '0, '0, 4'd4), 1'b0, none});
    // positions outside the legal range go into the box as they are
    dir_rows.push_back('{mk_obj(OP_RECORD, KIND_NODE, 64'sd77, 16'd3,
                                31'sh3FFF_FFFF, 32'sh7FFF_FFFF, 4'd0), 1'b0, none});
    dir_rows.push_back('{mk_obj(OP_RECORD, KIND_NODE, -64'sd77, 16'd3,
                                31'sh4000_0000, 32'sh8000_0000, 4'd0), 1'b0, none});
    // clear returns every statistic; the kept table is no longer readable
    dir_rows.push_back('{mk_obj(OP_CLEAR, KIND_NODE, '0, '0, '0, '0, 4'd0), 1'b1, rs});
    dir_rows.push_back('{mk_obj(OP_READ, KIND_NODE, '0, '0, '0, '0, 4'd0), 1'b1, rs});
    dir_rows.push_back('{mk_obj(OP_RECORD, KIND_NODE, 64'sd42, 16'd11,
                                31'sd10, -32'sd20, 4'd0), 1'b0, none});
    dir_rows.push_back('{mk_obj(OP_READ, KIND_NODE, '0, '0, '0, '0, 4'd0), 1'b0, none});
  endtask

  // Stimulus
  initial begin
    summary_t none;
    none = '0;
    acc = fresh_stats();
    ver_count = 0;
    for (int i = 0; i < VER_SLOTS; i++) ver_set[i] = '0;
    mismatches = 0; results_seen = 0; cycle_cnt = 0;
    n_records = 0; n_reads = 0; n_clears = 0; n_unused = 0;
    full_drops = 0; fill_peaks = 0;
    send_idle_pct = 17;
    recv_idle_pct = 76;
    load_directed();

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) send_item(dir_rows[i].obj, dir_rows[i].pinned, dir_rows[i].want);
    wait_drained();

    // three random phases: slow receiver, slow sender, no idling
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 17 : (ph == 1) ? 76 : 0;
      recv_idle_pct = (ph == 0) ? 76 : (ph == 1) ? 17 : 0;
      for (int n = 0; n < PHASE_ITEMS; n++) send_item(rand_obj(), 1'b0, none);
      wait_drained();
    end

    repeat (DRAIN_WAIT) @(posedge clk);
    $display("Covered %0d items: %0d records, %0d slot reads, %0d clears, %0d unused opcodes.",
             n_records + n_reads + n_clears + n_unused, n_records, n_reads, n_clears,
             n_unused);
    $display("%0d summaries checked; version set filled %0d times, %0d new versions dropped.",
             results_seen, fill_peaks, full_drops);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
